/* sv/ums_pkg.sv */
// ============================================================================
// Unicycle motion step package
// Shared constants, register indexes, the arctangent table and the side-band
// word that travels down the pipeline next to the arithmetic.
// ============================================================================
package ums_pkg;

    localparam int CORDIC_STAGES = 16;

    // Angles in Q.16 radians.
    localparam logic signed [19:0] TWO_PI  = 20'sd411775;
    localparam logic signed [19:0] PI      = 20'sd205887;
    localparam logic signed [19:0] HALF_PI = 20'sd102944;
    localparam logic [18:0]        TWO_PI_MAG = 19'd411775;

    // Limit gain of the rotation in Q.30.
    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

    // Reciprocal of 2*pi (Q.16) scaled by 2^RECIP_SHIFT, rounded down.
    localparam int          RECIP_SHIFT  = 40;
    localparam logic [21:0] TWO_PI_RECIP = 22'((64'd1 << RECIP_SHIFT) / 64'd411775);

    typedef enum logic [3:0] {
        REG_MAX_SPEED = 4'd0,
        REG_MAX_TURN  = 4'd1
    } cfg_reg_t;

    // Fields that ride along with each item. travel and heading are filled in
    // by the stage that first knows them.
    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [23:0]        speed;
        logic signed [23:0] turn_rate;
        logic [24:0]        travel;
        logic signed [19:0] heading;
    } ums_side_t;

    function automatic logic signed [19:0] atan_q16(input int idx);
        logic signed [19:0] res;
        unique case (idx)
            0:       res = 20'sd51472;
            1:       res = 20'sd30386;
            2:       res = 20'sd16055;
            3:       res = 20'sd8150;
            4:       res = 20'sd4091;
            5:       res = 20'sd2047;
            6:       res = 20'sd1024;
            7:       res = 20'sd512;
            8:       res = 20'sd256;
            9:       res = 20'sd128;
            10:      res = 20'sd64;
            11:      res = 20'sd32;
            12:      res = 20'sd16;
            13:      res = 20'sd8;
            14:      res = 20'sd4;
            15:      res = 20'sd2;
            16:      res = 20'sd1;
            default: res = 20'sd0;
        endcase
        return res;
    endfunction

endpackage

/* sv/unicycle_motion_step.sv */
// ============================================================================
// Unicycle motion step
// One kinematic update of a robot pose in fixed point: clamped speed and turn
// rate, trapezoid heading and distance, heading wrap and position advance.
// ============================================================================
//
// Channel   Direction  Handshake            Word
// input     in         in_valid / in_stall   pose, rates, accelerations, step
// output    out        out_valid / out_stall new pose, speed and turn rate
// config    in         cfg_we                cfg_index, cfg_data (24 bits)
//
// The depth is set by the rotation pipeline, one shift-add stage per
// iteration, plus four rate stages, three wrap stages, one offset multiply
// stage and the output register. One word can enter every cycle unless a
// stall on the output backs up into a full pipeline. Reset clears all valid
// bits and loads the speed limit with 0.5 m/s and the turn limit with 1 rad/s.
// A stall on the output only holds stages that carry a word; empty stages keep
// filling, so input is taken while a finished result waits, and nothing is
// lost or doubled.
//
module unicycle_motion_step
    import ums_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [3:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [19:0] heading,
    input  logic [23:0]        speed,
    input  logic signed [23:0] turn_rate,
    input  logic signed [23:0] accel,
    input  logic signed [23:0] turn_accel,
    input  logic [15:0]        step_time,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] next_x,
    output logic signed [31:0] next_y,
    output logic signed [19:0] next_heading,
    output logic [23:0]        next_speed,
    output logic signed [23:0] next_turn_rate
);

    // Limit registers. Writes to indexes outside the list are dropped.
    logic [23:0] vmax_reg;
    logic [22:0] wmax_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vmax_reg <= 24'd32768;
            wmax_reg <= 23'd65536;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_MAX_SPEED)
            begin
                vmax_reg <= cfg_data;
            end
            if (cfg_index == REG_MAX_TURN)
            begin
                wmax_reg <= cfg_data[22:0];
            end
        end
    end

    // Rate update and trapezoid products.
    logic               kin_valid, kin_rdy, in_rdy;
    logic signed [25:0] kin_ang;
    ums_side_t          kin_side;

    ums_kin u_kin (
        .clk        (clk),
        .rst_n      (rst_n),
        .vmax       (vmax_reg),
        .wmax       (wmax_reg),
        .up_valid   (in_valid),
        .up_rdy     (in_rdy),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .heading    (heading),
        .speed      (speed),
        .turn_rate  (turn_rate),
        .accel      (accel),
        .turn_accel (turn_accel),
        .step_time  (step_time),
        .dn_valid   (kin_valid),
        .dn_rdy     (kin_rdy),
        .ang_raw    (kin_ang),
        .side       (kin_side)
    );

    assign in_stall = !in_rdy;

    // Heading remainder and quadrant fold.
    logic               wrap_valid, wrap_rdy, wrap_flip;
    logic signed [19:0] wrap_z;
    ums_side_t          wrap_side;

    ums_wrap u_wrap (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (kin_valid),
        .up_rdy   (kin_rdy),
        .ang_raw  (kin_ang),
        .up_side  (kin_side),
        .dn_valid (wrap_valid),
        .dn_rdy   (wrap_rdy),
        .z        (wrap_z),
        .flip     (wrap_flip),
        .dn_side  (wrap_side)
    );

    // Cosine and sine of the new heading.
    logic               cor_valid, cor_rdy, cor_flip;
    logic signed [32:0] cor_cos, cor_sin;
    ums_side_t          cor_side;

    ums_cordic u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (wrap_valid),
        .up_rdy   (wrap_rdy),
        .z_in     (wrap_z),
        .flip_in  (wrap_flip),
        .up_side  (wrap_side),
        .dn_valid (cor_valid),
        .dn_rdy   (cor_rdy),
        .cos_out  (cor_cos),
        .sin_out  (cor_sin),
        .flip_out (cor_flip),
        .dn_side  (cor_side)
    );

    // Offset products: distance (Q.16) times cos or sin (Q.30). A fold by pi
    // negates cos and sin before the multiply.
    logic               m1_v_reg, m1_rdy, out_rdy;
    logic signed [58:0] px_prod_reg, py_prod_reg;
    ums_side_t          m1_side_reg;
    logic signed [32:0] cos_adj, sin_adj;

    assign out_rdy = !out_valid || !out_stall;
    assign m1_rdy  = !m1_v_reg || out_rdy;
    assign cor_rdy = m1_rdy;

    assign cos_adj = cor_flip ? -cor_cos : cor_cos;
    assign sin_adj = cor_flip ? -cor_sin : cor_sin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_v_reg <= 1'b0;
        end
        else if (m1_rdy)
        begin
            m1_v_reg <= cor_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m1_rdy)
        begin
            px_prod_reg <= $signed({1'b0, cor_side.travel}) * cos_adj;
            py_prod_reg <= $signed({1'b0, cor_side.travel}) * sin_adj;
            m1_side_reg <= cor_side;
        end
    end

    // Output register: round the offsets to Q.16 and add, wrapping at 32 bits.
    logic               out_v_reg;
    logic signed [58:0] rx, ry;
    logic signed [31:0] nx_reg, ny_reg;
    ums_side_t          out_side_reg;

    assign rx = px_prod_reg + 59'sd536870912;
    assign ry = py_prod_reg + 59'sd536870912;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (out_rdy)
        begin
            out_v_reg <= m1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_rdy)
        begin
            nx_reg       <= m1_side_reg.px + 32'($signed(rx[58:30]));
            ny_reg       <= m1_side_reg.py + 32'($signed(ry[58:30]));
            out_side_reg <= m1_side_reg;
        end
    end

    assign out_valid      = out_v_reg;
    assign next_x         = nx_reg;
    assign next_y         = ny_reg;
    assign next_heading   = out_side_reg.heading;
    assign next_speed     = out_side_reg.speed;
    assign next_turn_rate = out_side_reg.turn_rate;

endmodule

/* sv/ums_kin.sv */
// ============================================================================
// Unicycle motion step: rate update
// Four stages: acceleration products, clamp and round of the new rates,
// trapezoid products, and rounding of heading change and distance.
// ============================================================================
module ums_kin
    import ums_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [23:0]        vmax,
    input  logic [22:0]        wmax,
    input  logic               up_valid,
    output logic               up_rdy,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [19:0] heading,
    input  logic [23:0]        speed,
    input  logic signed [23:0] turn_rate,
    input  logic signed [23:0] accel,
    input  logic signed [23:0] turn_accel,
    input  logic [15:0]        step_time,
    output logic               dn_valid,
    input  logic               dn_rdy,
    output logic signed [25:0] ang_raw,
    output ums_side_t          side
);

    localparam int NS = 4;

    logic [NS-1:0] v_reg;
    logic [NS:0]   rdy;

    assign rdy[NS] = dn_rdy;
    genvar g;
    generate
        for (g = 0; g < NS; g++) begin : g_rdy
            assign rdy[g] = !v_reg[g] || rdy[g+1];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= up_valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    assign up_rdy   = rdy[0];
    assign dn_valid = v_reg[NS-1];

    // Stage 1: acceleration times step.
    logic signed [40:0] pv1_reg, pw1_reg;
    logic [23:0]        vo1_reg;
    logic signed [23:0] wo1_reg;
    logic [15:0]        dt1_reg;
    logic signed [19:0] hd1_reg;
    ums_side_t          side1_reg;
    ums_side_t          side1_next;
    logic signed [40:0] pv1_next, pw1_next;

    assign pv1_next = accel * $signed({1'b0, step_time});
    assign pw1_next = turn_accel * $signed({1'b0, step_time});

    always_comb
    begin
        side1_next           = '0;
        side1_next.px        = pos_x;
        side1_next.py        = pos_y;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            pv1_reg   <= pv1_next;
            pw1_reg   <= pw1_next;
            vo1_reg   <= speed;
            wo1_reg   <= turn_rate;
            dt1_reg   <= step_time;
            hd1_reg   <= heading;
            side1_reg <= side1_next;
        end
    end

    // Stage 2: new rates, clamped in Q.32 and rounded half up to Q.16.
    logic signed [41:0] vs, ws, vs_r, ws_r, vmax_ext, wmax_ext;
    logic [23:0]        vn2_next;
    logic signed [23:0] wn2_next;
    logic [23:0]        vn2_reg, vo2_reg;
    logic signed [23:0] wn2_reg, wo2_reg;
    logic [15:0]        dt2_reg;
    logic signed [19:0] hd2_reg;
    ums_side_t          side2_reg;
    ums_side_t          side2_next;

    assign vs       = $signed({2'b00, vo1_reg, 16'd0}) + 42'(pv1_reg);
    assign ws       = 42'($signed({wo1_reg, 16'd0})) + 42'(pw1_reg);
    assign vs_r     = vs + 42'sd32768;
    assign ws_r     = ws + 42'sd32768;
    assign vmax_ext = $signed({2'b00, vmax, 16'd0});
    assign wmax_ext = $signed({3'b000, wmax, 16'd0});

    always_comb
    begin
        priority if (vs > vmax_ext)
        begin
            vn2_next = vmax;
        end
        else if (vs < 42'sd0)
        begin
            vn2_next = '0;
        end
        else
        begin
            vn2_next = vs_r[39:16];
        end

        priority if (ws > wmax_ext)
        begin
            wn2_next = $signed({1'b0, wmax});
        end
        else if (ws < -wmax_ext)
        begin
            wn2_next = -$signed({1'b0, wmax});
        end
        else
        begin
            wn2_next = ws_r[39:16];
        end
    end

    always_comb
    begin
        side2_next           = side1_reg;
        side2_next.speed     = vn2_next;
        side2_next.turn_rate = wn2_next;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            vn2_reg   <= vn2_next;
            wn2_reg   <= wn2_next;
            vo2_reg   <= vo1_reg;
            wo2_reg   <= wo1_reg;
            dt2_reg   <= dt1_reg;
            hd2_reg   <= hd1_reg;
            side2_reg <= side2_next;
        end
    end

    // Stage 3: step times the sum of old and new rate.
    logic signed [24:0] wsum;
    logic [24:0]        vsum;
    logic signed [41:0] pw3_reg, pw3_next;
    logic [40:0]        pv3_reg, pv3_next;
    logic signed [19:0] hd3_reg;
    ums_side_t          side3_reg;

    assign wsum     = 25'(wo2_reg) + 25'(wn2_reg);
    assign vsum     = {1'b0, vo2_reg} + {1'b0, vn2_reg};
    assign pw3_next = wsum * $signed({1'b0, dt2_reg});
    assign pv3_next = 41'(vsum) * 41'(dt2_reg);

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            pw3_reg   <= pw3_next;
            pv3_reg   <= pv3_next;
            hd3_reg   <= hd2_reg;
            side3_reg <= side2_reg;
        end
    end

    // Stage 4: halve and round, then add the heading change.
    logic signed [41:0] dh_full;
    logic [41:0]        dist_full;
    logic signed [24:0] dh;
    logic signed [25:0] ang4_reg;
    ums_side_t          side4_reg;
    ums_side_t          side4_next;

    assign dh_full   = pw3_reg + 42'sd65536;
    assign dist_full = 42'(pv3_reg) + 42'd65536;
    assign dh        = dh_full[41:17];

    always_comb
    begin
        side4_next        = side3_reg;
        side4_next.travel = dist_full[41:17];
    end

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            ang4_reg  <= 26'(hd3_reg) + 26'(dh);
            side4_reg <= side4_next;
        end
    end

    assign ang_raw = ang4_reg;
    assign side    = side4_reg;

endmodule

/* sv/ums_wrap.sv */
// ============================================================================
// Unicycle motion step: heading wrap
// Remainder modulo 2*pi by reciprocal multiply with one correction, then the
// fold of the angle into plus or minus pi/2 for the rotation unit.
// ============================================================================
module ums_wrap
    import ums_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_rdy,
    input  logic signed [25:0] ang_raw,
    input  ums_side_t          up_side,
    output logic               dn_valid,
    input  logic               dn_rdy,
    output logic signed [19:0] z,
    output logic               flip,
    output ums_side_t          dn_side
);

    localparam int NS = 3;

    logic [NS-1:0] v_reg;
    logic [NS:0]   rdy;

    assign rdy[NS] = dn_rdy;
    genvar g;
    generate
        for (g = 0; g < NS; g++) begin : g_rdy
            assign rdy[g] = !v_reg[g] || rdy[g+1];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= up_valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    assign up_rdy   = rdy[0];
    assign dn_valid = v_reg[NS-1];

    // Stage 1: magnitude and its scaled quotient estimate.
    logic [24:0] mag, mag1_reg;
    logic        sgn1_reg;
    logic [46:0] prod1_reg;
    ums_side_t   side1_reg;

    assign mag = ang_raw[25] ? 25'(-ang_raw) : 25'(ang_raw);

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            mag1_reg  <= mag;
            sgn1_reg  <= ang_raw[25];
            prod1_reg <= 47'(mag) * 47'(TWO_PI_RECIP);
            side1_reg <= up_side;
        end
    end

    // Stage 2: remainder, corrected once, sign restored (truncating remainder).
    logic [6:0]         quot;
    logic [25:0]        rem0, rem1;
    logic [18:0]        rem;
    logic signed [19:0] wrapped;
    ums_side_t          side2_reg;
    ums_side_t          side2_next;

    assign quot    = prod1_reg[46:RECIP_SHIFT];
    assign rem0    = 26'(mag1_reg) - 26'(quot) * 26'(TWO_PI_MAG);
    assign rem1    = (rem0 >= 26'(TWO_PI_MAG)) ? rem0 - 26'(TWO_PI_MAG) : rem0;
    assign rem     = rem1[18:0];
    assign wrapped = sgn1_reg ? -$signed({1'b0, rem}) : $signed({1'b0, rem});

    always_comb
    begin
        side2_next         = side1_reg;
        side2_next.heading = wrapped;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            side2_reg <= side2_next;
        end
    end

    // Stage 3: fold into plus or minus pi/2; a fold by pi flips the result sign.
    logic signed [19:0] a0, a1;
    logic               f1;
    logic signed [19:0] z3_reg;
    logic               f3_reg;
    ums_side_t          side3_reg;

    always_comb
    begin
        a0 = side2_reg.heading;
        priority if (a0 > PI)
        begin
            a0 = a0 - TWO_PI;
        end
        else if (a0 < -PI)
        begin
            a0 = a0 + TWO_PI;
        end
        else
        begin
            a0 = a0;
        end

        priority if (a0 > HALF_PI)
        begin
            a1 = a0 - PI;
            f1 = 1'b1;
        end
        else if (a0 < -HALF_PI)
        begin
            a1 = a0 + PI;
            f1 = 1'b1;
        end
        else
        begin
            a1 = a0;
            f1 = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            z3_reg    <= a1;
            f3_reg    <= f1;
            side3_reg <= side2_reg;
        end
    end

    assign z       = z3_reg;
    assign flip    = f3_reg;
    assign dn_side = side3_reg;

endmodule

/* sv/ums_cordic.sv */
// ============================================================================
// Unicycle motion step: rotation pipeline
// One shift-add rotation per stage, producing cos and sin in Q.30.
// ============================================================================
module ums_cordic
    import ums_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_rdy,
    input  logic signed [19:0] z_in,
    input  logic               flip_in,
    input  ums_side_t          up_side,
    output logic               dn_valid,
    input  logic               dn_rdy,
    output logic signed [32:0] cos_out,
    output logic signed [32:0] sin_out,
    output logic               flip_out,
    output ums_side_t          dn_side
);

    localparam int NS = CORDIC_STAGES;

    logic [NS-1:0] v_reg;
    logic [NS:0]   rdy;

    logic signed [32:0] x_reg [NS];
    logic signed [32:0] y_reg [NS];
    logic signed [19:0] z_reg [NS];
    logic               f_reg [NS];
    ums_side_t          s_reg [NS];

    assign rdy[NS] = dn_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= up_valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < NS; g++) begin : g_stage
            logic signed [32:0] xi, yi, xs, ys;
            logic signed [19:0] zi;
            logic               fi;
            ums_side_t          si;

            assign rdy[g] = !v_reg[g] || rdy[g+1];

            if (g == 0) begin : g_first
                assign xi = CORDIC_GAIN;
                assign yi = '0;
                assign zi = z_in;
                assign fi = flip_in;
                assign si = up_side;
            end
            else begin : g_next
                assign xi = x_reg[g-1];
                assign yi = y_reg[g-1];
                assign zi = z_reg[g-1];
                assign fi = f_reg[g-1];
                assign si = s_reg[g-1];
            end

            assign xs = xi >>> g;
            assign ys = yi >>> g;

            always_ff @(posedge clk)
            begin
                if (rdy[g])
                begin
                    if (!zi[19])
                    begin
                        x_reg[g] <= xi - ys;
                        y_reg[g] <= yi + xs;
                        z_reg[g] <= zi - atan_q16(g);
                    end
                    else
                    begin
                        x_reg[g] <= xi + ys;
                        y_reg[g] <= yi - xs;
                        z_reg[g] <= zi + atan_q16(g);
                    end
                    f_reg[g] <= fi;
                    s_reg[g] <= si;
                end
            end
        end
    endgenerate

    assign up_rdy   = rdy[0];
    assign dn_valid = v_reg[NS-1];
    assign cos_out  = x_reg[NS-1];
    assign sin_out  = y_reg[NS-1];
    assign flip_out = f_reg[NS-1];
    assign dn_side  = s_reg[NS-1];

endmodule

/* sv/ums_checker.sv */
// ============================================================================
// Unicycle motion step checker
// Port-level checks on the result words and their handshake.
// ============================================================================
module ums_checker
    import ums_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [3:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] next_x,
    input  logic signed [31:0] next_y,
    input  logic signed [19:0] next_heading,
    input  logic [23:0]        next_speed,
    input  logic signed [23:0] next_turn_rate
);

    // Copies of the limit registers as seen on the configuration port.
    logic [23:0] vmax_reg;
    logic [22:0] wmax_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vmax_reg <= 24'd32768;
            wmax_reg <= 23'd65536;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_MAX_SPEED)
            begin
                vmax_reg <= cfg_data;
            end
            if (cfg_index == REG_MAX_TURN)
            begin
                wmax_reg <= cfg_data[22:0];
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(next_x) && $stable(next_y))
        else $error("result word changed while stalled");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> next_heading < TWO_PI && next_heading > -TWO_PI)
        else $error("heading outside plus or minus 2 pi");

    a_speed_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> next_speed <= vmax_reg)
        else $error("speed above limit");

    a_turn_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> next_turn_rate <= $signed({1'b0, wmax_reg})
                   && next_turn_rate >= -$signed({1'b0, wmax_reg}))
        else $error("turn rate above limit");

endmodule

bind unicycle_motion_step ums_checker u_ums_checker (.*);

/* test/unicycle_motion_step_tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// Unicycle motion step testbench
// Feeds pose words through the pipeline under several speed and turn limits,
// predicts every new pose in fixed point, including the trapezoid rates, the
// heading wrap and the rotation, and checks each result word field by field
// while both channels idle in random bursts in all but the final phase.
// ============================================================================
module unicycle_motion_step_tb
    import ums_pkg::*;
;

    localparam int LIMIT_CYCLES = 300000;
    localparam int DRAIN_CYCLES = 40;
    // An index that names no register; writes to it must be dropped.
    localparam logic [3:0] REG_UNUSED = 4'd9;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [19:0] heading;
        logic [23:0]        speed;
        logic signed [23:0] turn_rate;
        logic signed [23:0] accel;
        logic signed [23:0] turn_accel;
        logic [15:0]        step_time;
    } pose_word_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [19:0] hd;
        logic [23:0]        v;
        logic signed [23:0] w;
    } pose_next_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [3:0] cfg_index = '0;
    logic [23:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [31:0] pos_x = '0;
    logic signed [31:0] pos_y = '0;
    logic signed [19:0] heading = '0;
    logic [23:0] speed = '0;
    logic signed [23:0] turn_rate = '0;
    logic signed [23:0] accel = '0;
    logic signed [23:0] turn_accel = '0;
    logic [15:0] step_time = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] next_x;
    logic signed [31:0] next_y;
    logic signed [19:0] next_heading;
    logic [23:0] next_speed;
    logic signed [23:0] next_turn_rate;

    // Testbench copy of the limits, changed only while the pipeline is empty.
    logic [23:0] speed_limit = 24'd32768;
    logic [22:0] turn_limit = 23'd65536;

    pose_word_t pending_words[$];
    pose_next_t expected_poses[$];
    int errors = 0;
    int words_checked = 0;
    int cycle_count = 0;
    bit quiet = 1'b0;

    unicycle_motion_step u_top (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor. Shifts on longint are arithmetic, so they round toward minus
    // infinity, and the remainder truncates toward zero like fmod.
    // ------------------------------------------------------------------------
    function automatic longint round_q(input longint v, input int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic void rotate(input longint ang, output longint c, output longint s);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        bit flip;
        x = longint'(CORDIC_GAIN);
        y = 0;
        flip = 1'b0;
        if (ang > PI) ang -= TWO_PI;
        if (ang < -PI) ang += TWO_PI;
        // Fold into the right half plane; a fold by pi negates the vector.
        if (ang > HALF_PI)
        begin
            ang -= PI;
            flip = 1'b1;
        end
        else if (ang < -HALF_PI)
        begin
            ang += PI;
            flip = 1'b1;
        end
        z = ang;
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x -= ys;
                y += xs;
                z -= longint'(atan_q16(i));
            end
            else
            begin
                x += ys;
                y -= xs;
                z += longint'(atan_q16(i));
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic pose_next_t advance_pose(input pose_word_t p);
        pose_next_t r;
        longint dt;
        longint vo;
        longint wo;
        longint vmax;
        longint wmax;
        longint sum;
        longint vn;
        longint wn;
        longint hd;
        longint travel;
        longint c;
        longint s;
        longint nx;
        longint ny;
        dt = longint'(p.step_time);
        vo = longint'(p.speed);
        wo = longint'(p.turn_rate);
        vmax = longint'(speed_limit);
        wmax = longint'(turn_limit);
        // Rates are clamped in Q.32 before rounding back to Q.16.
        sum = vo * 65536 + longint'(p.accel) * dt;
        if (sum > vmax * 65536) vn = vmax;
        else if (sum < 0) vn = 0;
        else vn = round_q(sum, 16);
        sum = wo * 65536 + longint'(p.turn_accel) * dt;
        if (sum > wmax * 65536) wn = wmax;
        else if (sum < -wmax * 65536) wn = -wmax;
        else wn = round_q(sum, 16);
        hd = longint'(p.heading) + round_q(dt * (wo + wn), 17);
        hd = hd % longint'(TWO_PI);
        travel = round_q(dt * (vo + vn), 17);
        rotate(hd, c, s);
        nx = longint'(p.pos_x) + round_q(travel * c, 30);
        ny = longint'(p.pos_y) + round_q(travel * s, 30);
        r.x = nx[31:0];
        r.y = ny[31:0];
        r.hd = hd[19:0];
        r.v = vn[23:0];
        r.w = wn[23:0];
        return r;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        errors++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------------
    // Driver. A new word is presented only when the channel is free, so a
    // stalled word holds still; idle bursts are drawn between words.
    // ------------------------------------------------------------------------
    int idle_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        pose_word_t w;
        bit present;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
                expected_poses.insert(expected_poses.size(),
                    advance_pose({pos_x, pos_y, heading, speed,
                    turn_rate, accel, turn_accel, step_time}));
            present = 1'b0;
            if (idle_left > 0)
                idle_left--;
            else if (pending_words.size() > 0)
            begin
                if (!quiet && $urandom_range(0, 7) == 0)
                    idle_left = $urandom_range(1, 5) - 1;
                else
                    present = 1'b1;
            end
            if (present)
            begin
                w = pending_words.pop_front();
                pos_x <= w.pos_x;
                pos_y <= w.pos_y;
                heading <= w.heading;
                speed <= w.speed;
                turn_rate <= w.turn_rate;
                accel <= w.accel;
                turn_accel <= w.turn_accel;
                step_time <= w.step_time;
            end
            in_valid <= present;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Checks each accepted result word against the oldest prediction
    // and drives the output stall in random bursts.
    // ------------------------------------------------------------------------
    int stall_left = 0;

    always @(posedge clk)
    begin
        pose_next_t e;
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
        else if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_poses.size() == 0)
                begin
                    errors++;
                    $display("[%0t] result word with no prediction waiting", $time);
                end
                else
                begin
                    e = expected_poses.pop_front();
                    words_checked++;
                    if (next_x !== e.x) report("next_x", next_x, e.x);
                    if (next_y !== e.y) report("next_y", next_y, e.y);
                    if (next_heading !== e.hd) report("next_heading", next_heading, e.hd);
                    if (next_speed !== e.v) report("next_speed", next_speed, e.v);
                    if (next_turn_rate !== e.w)
                        report("next_turn_rate", next_turn_rate, e.w);
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 5) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic add_word(input logic [31:0] px, input logic [31:0] py,
                            input logic [19:0] hd, input logic [23:0] v,
                            input logic [23:0] w, input logic [23:0] a,
                            input logic [23:0] ta, input logic [15:0] dt);
        pose_word_t p;
        p = {px, py, hd, v, w, a, ta, dt};
        pending_words.insert(pending_words.size(), p);
    endtask

    // Mostly plausible poses so that the clamps sit near the edge; now and
    // then a word with every bit random.
    task automatic add_random_word();
        logic [19:0] hd;
        if ($urandom_range(0, 4) == 0)
        begin
            add_word($urandom, $urandom, 20'($urandom), 24'($urandom), 24'($urandom),
                     24'($urandom), 24'($urandom), 16'($urandom));
        end
        else
        begin
            hd = 20'($urandom_range(0, 823550)) - 20'd411775;
            add_word($urandom, $urandom, hd,
                     24'($urandom_range(0, 2 * speed_limit + 16)),
                     24'($signed($urandom_range(0, 4 * turn_limit + 32)) -
                         $signed(2 * turn_limit + 16)),
                     24'($signed($urandom_range(0, 1 << 20)) - (1 << 19)),
                     24'($signed($urandom_range(0, 1 << 21)) - (1 << 20)),
                     ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom));
        end
    endtask

    task automatic write_limit(input logic [3:0] idx, input logic [23:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_MAX_SPEED) speed_limit = val;
        else if (idx == REG_MAX_TURN) turn_limit = val[22:0];
    endtask

    // Waits until the pipeline has handed back every prediction, then lets
    // the pipeline run empty for its full depth.
    task automatic drain();
        do @(posedge clk);
        while (pending_words.size() != 0 || in_valid || expected_poses.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase(input int count);
        repeat (count) add_random_word();
        drain();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words under the reset limits.
        add_word(0, 0, 0, 0, 0, 0, 0, 0);
        add_word(32'h7fffffff, 32'h80000000, 20'sd411775, 24'hffffff,
                 24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 16'hffff);
        add_word(32'h80000000, 32'h7fffffff, -20'sd411775, 24'h0,
                 24'sh800000, 24'sh800000, 24'sh800000, 16'hffff);
        // Zero step with old rates beyond the limits: only the clamps act.
        add_word(32'h00010000, 32'h00020000, 20'sd1000, 24'hffffff,
                 -24'sd9000000, 24'sd5000, 24'sd5000, 16'd0);
        // Headings outside the nominal range, at the 20-bit extremes.
        add_word(0, 0, 20'h7ffff, 24'd32768, 24'd65536, 0, 0, 16'h8000);
        add_word(0, 0, 20'h80000, 24'd32768, -24'sd65536, 0, 0, 16'h8000);
        // Quarter and half turns, both signs, to cover every fold.
        add_word(0, 0, 20'sd102944, 24'd32768, 0, 0, 0, 16'hffff);
        add_word(0, 0, -20'sd102944, 24'd32768, 0, 0, 0, 16'hffff);
        add_word(0, 0, 20'sd205887, 24'd32768, 0, 0, 0, 16'hffff);
        add_word(0, 0, -20'sd205887, 24'd32768, 0, 0, 0, 16'hffff);
        add_word(0, 0, 20'sd300000, 24'd20000, 24'd40000, 0, 0, 16'h4000);
        add_word(0, 0, -20'sd300000, 24'd20000, -24'd40000, 0, 0, 16'h4000);
        // Speed hitting zero and the limit, rate hitting both limits.
        add_word(0, 0, 0, 24'd100, 0, -24'sd3000000, 24'sd3000000, 16'hffff);
        add_word(0, 0, 0, 24'd32000, 24'd65000, 24'sd3000000, -24'sd3000000, 16'hffff);
        // Exact halves in the rate rounding.
        add_word(0, 0, 0, 24'd10, 24'd10, 24'sd1, -24'sd1, 16'h8000);
        add_word(32'h7fff0000, 32'h7fff0000, 20'sd51472, 24'd32768, 0, 0, 0, 16'hffff);
        drain();

        // Widest limits, with a write to an unused index that must be dropped.
        write_limit(REG_MAX_SPEED, 24'hffffff);
        write_limit(REG_MAX_TURN, 24'h7fffff);
        write_limit(REG_UNUSED, 24'd0);
        add_word(32'h7fffffff, 32'h7fffffff, 20'sd25000, 24'hffffff, 24'sh7fffff,
                 24'sh7fffff, 24'sh7fffff, 16'hffff);
        add_word(32'h80000000, 32'h80000000, -20'sd25000, 24'hffffff, 24'sh800000,
                 24'sh7fffff, 24'sh800000, 16'hffff);
        random_phase(200);

        // Zero limits: new speed and turn rate are clamped to zero.
        write_limit(REG_MAX_SPEED, 24'd0);
        write_limit(REG_MAX_TURN, 24'd0);
        random_phase(150);

        write_limit(REG_MAX_SPEED, 24'd300000);
        write_limit(REG_MAX_TURN, 24'd200000);
        random_phase(250);

        write_limit(REG_MAX_SPEED, 24'($urandom));
        write_limit(REG_MAX_TURN, 24'($urandom_range(0, 23'h7fffff)));
        random_phase(200);

        // Final stretch back at the reset limits with no idling on either side.
        write_limit(REG_MAX_SPEED, 24'd32768);
        write_limit(REG_MAX_TURN, 24'd65536);
        quiet = 1'b1;
        random_phase(220);

        $display("Checked %0d result words across six limit settings,", words_checked);
        $display("with stalls, zero steps, wraps and clamps; %0d mismatches.", errors);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
